FILE: src/qftv_pkg.sv
// shared types, constants and helpers for the quaternion-from-two-vectors block
package qftv_pkg;

  localparam int FIFO_DEPTH  = 32;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int SQRT_BITS   = 32;
  localparam int SQRT_STAGES = 8;
  localparam int SQRT_STEPS  = SQRT_BITS / SQRT_STAGES;
  localparam int QBITS       = 15;
  localparam int DIV_STAGES  = 5;
  localparam int DIV_STEPS   = QBITS / DIV_STAGES;
  localparam int DIV_RW      = 47;
  localparam int LATENCY     = 30;

  localparam logic [19:0] OPP_SCALE = 20'd1000000;
  localparam logic [5:0]  NORM_MSB  = 6'd29;

  typedef struct packed {
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic signed [15:0] src_z;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic signed [15:0] dst_z;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               opposite_flag;
    logic               zero_input_flag;
  } quat_t;

  typedef struct packed {
    logic [FIFO_AW:0] level;
    logic             full;
    logic             empty;
  } fifo_stat_t;

  function automatic logic signed [31:0] smul16(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
    logic signed [31:0] ea, eb;
    ea = 32'(a);
    eb = 32'(b);
    return ea * eb;
  endfunction

  // position of the highest set bit
  function automatic logic [5:0] lead_pos(input logic [32:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

FILE: src/qftv_isqrt.sv
// pipelined integer square root of a 64-bit radicand, four root bits per stage
module qftv_isqrt (
  input  logic                            clk,
  input  logic [63:0]                     rad,
  output logic [qftv_pkg::SQRT_BITS-1:0]  root
);

  logic [63:0] op_r  [qftv_pkg::SQRT_STAGES];
  logic [63:0] res_r [qftv_pkg::SQRT_STAGES];

  for (genvar s = 0; s < qftv_pkg::SQRT_STAGES; s++) begin : g_stage
    logic [63:0] op_in, res_in;
    logic [63:0] op_c, res_c, bit_c, trial;

    if (s == 0) begin : g_first
      assign op_in  = rad;
      assign res_in = '0;
    end else begin : g_rest
      assign op_in  = op_r[s-1];
      assign res_in = res_r[s-1];
    end

    always_comb begin
      op_c  = op_in;
      res_c = res_in;
      bit_c = '0;
      trial = '0;
      for (int j = 0; j < qftv_pkg::SQRT_STEPS; j++) begin
        bit_c = 64'd1 << (62 - 2 * (s * qftv_pkg::SQRT_STEPS + j));
        trial = res_c + bit_c;
        if (op_c >= trial) begin
          op_c  = op_c - trial;
          res_c = (res_c >> 1) + bit_c;
        end else begin
          res_c = res_c >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      op_r[s]  <= op_c;
      res_r[s] <= res_c;
    end
  end

  assign root = res_r[qftv_pkg::SQRT_STAGES-1][qftv_pkg::SQRT_BITS-1:0];

endmodule

FILE: src/qftv_div.sv
// pipelined restoring divider giving round(mag * 2^14 / nrm)
module qftv_div (
  input  logic                        clk,
  input  logic [29:0]                 mag,
  input  logic [30:0]                 nrm,
  output logic [qftv_pkg::QBITS-1:0]  quo
);

  logic [qftv_pkg::DIV_RW-1:0] rem_r [qftv_pkg::DIV_STAGES];
  logic [31:0]                 den_r [qftv_pkg::DIV_STAGES];
  logic [qftv_pkg::QBITS-1:0]  quo_r [qftv_pkg::DIV_STAGES];

  for (genvar s = 0; s < qftv_pkg::DIV_STAGES; s++) begin : g_stage
    logic [qftv_pkg::DIV_RW-1:0] rem_in, rem_c, sub_c;
    logic [31:0]                 den_in;
    logic [qftv_pkg::QBITS-1:0]  quo_in, quo_c;

    if (s == 0) begin : g_first
      // dividend a*2^15 + n, divisor 2n
      assign rem_in = qftv_pkg::DIV_RW'({mag, {qftv_pkg::QBITS{1'b0}}})
                    + qftv_pkg::DIV_RW'(nrm);
      assign den_in = {nrm, 1'b0};
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin
      rem_c = rem_in;
      quo_c = quo_in;
      sub_c = '0;
      for (int j = 0; j < qftv_pkg::DIV_STEPS; j++) begin
        sub_c = qftv_pkg::DIV_RW'(den_in)
                << (qftv_pkg::QBITS - 1 - (s * qftv_pkg::DIV_STEPS + j));
        if (rem_c >= sub_c) begin
          rem_c = rem_c - sub_c;
          quo_c = {quo_c[qftv_pkg::QBITS-2:0], 1'b1};
        end else begin
          quo_c = {quo_c[qftv_pkg::QBITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_c;
      den_r[s] <= den_in;
      quo_r[s] <= quo_c;
    end
  end

  assign quo = quo_r[qftv_pkg::DIV_STAGES-1];

endmodule

FILE: src/qftv_fifo.sv
// result buffer that absorbs the pipeline contents while the output stalls
module qftv_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  qftv_pkg::quat_t      wdata,
  input  logic                 pop,
  output qftv_pkg::quat_t      rdata,
  output qftv_pkg::fifo_stat_t stat
);

  qftv_pkg::quat_t mem [qftv_pkg::FIFO_DEPTH];

  logic [qftv_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [qftv_pkg::FIFO_AW:0]   level;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  assign rdata       = mem[rd_ptr];
  assign stat.level  = level;
  assign stat.full   = (level == (qftv_pkg::FIFO_AW+1)'(qftv_pkg::FIFO_DEPTH));
  assign stat.empty  = (level == '0);

endmodule

FILE: src/quat_from_two_vectors.sv
// top level: unit quaternion rotating one Q4.12 vector onto another
//
//   channel | signals                      | word
//   --------+------------------------------+-----------------------------
//   vec     | vec_valid, vec_ready, vec    | src_x..dst_x..dst_z, Q4.12
//   quat    | quat_valid, quat_ready, quat | quat_w..quat_z Q1.14, flags
//
// one word per cycle while vec_ready is high; a result is offered once the word
// has passed 30 pipeline registers (two 8-stage square roots, a 5-stage divider,
// 9 others) and been written into the result buffer
// the pipeline never stalls; a 32-entry result buffer and a credit counter
// hold vec_ready low outside reset only when every slot is spoken for and no word leaves
// reset (synchronous) empties the pipeline valid bits, credits and buffer
module quat_from_two_vectors (
  input  logic            clk,
  input  logic            rst,
  input  logic            vec_valid,
  output logic            vec_ready,
  input  qftv_pkg::vec_t  vec,
  output logic            quat_valid,
  input  logic            quat_ready,
  output qftv_pkg::quat_t quat
);

  typedef struct packed {
    logic signed [33:0] dot;
    logic signed [32:0] cx;
    logic signed [32:0] cy;
    logic signed [32:0] cz;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] sz;
    logic               zero;
  } front_t;

  typedef struct packed {
    logic [3:0][29:0] mag;
    logic [3:0]       neg;
    logic             opp;
    logic             zero;
  } back_t;

  typedef struct packed {
    logic [3:0] neg;
    logic       opp;
    logic       zero;
  } tail_t;

  logic accept, push, pop;
  logic [qftv_pkg::LATENCY-1:0] vld;
  logic [qftv_pkg::FIFO_AW:0]   credit;
  qftv_pkg::fifo_stat_t fstat;
  qftv_pkg::quat_t      res;

  // stage a: products and sums
  front_t       fr_c, fr_a, fr_b, fr_c2, fr_d;
  logic [31:0]  ls_c, ld_c, ls_a, ld_a;
  logic signed [31:0] p_sxx, p_syy, p_szz, p_dxx, p_dyy, p_dzz;
  logic signed [31:0] p_xx, p_yy, p_zz;
  logic signed [31:0] p_ydz, p_zdy, p_zdx, p_xdz, p_xdy, p_ydx;

  always_comb begin
    p_sxx = qftv_pkg::smul16(vec.src_x, vec.src_x);
    p_syy = qftv_pkg::smul16(vec.src_y, vec.src_y);
    p_szz = qftv_pkg::smul16(vec.src_z, vec.src_z);
    p_dxx = qftv_pkg::smul16(vec.dst_x, vec.dst_x);
    p_dyy = qftv_pkg::smul16(vec.dst_y, vec.dst_y);
    p_dzz = qftv_pkg::smul16(vec.dst_z, vec.dst_z);
    p_xx  = qftv_pkg::smul16(vec.src_x, vec.dst_x);
    p_yy  = qftv_pkg::smul16(vec.src_y, vec.dst_y);
    p_zz  = qftv_pkg::smul16(vec.src_z, vec.dst_z);
    p_ydz = qftv_pkg::smul16(vec.src_y, vec.dst_z);
    p_zdy = qftv_pkg::smul16(vec.src_z, vec.dst_y);
    p_zdx = qftv_pkg::smul16(vec.src_z, vec.dst_x);
    p_xdz = qftv_pkg::smul16(vec.src_x, vec.dst_z);
    p_xdy = qftv_pkg::smul16(vec.src_x, vec.dst_y);
    p_ydx = qftv_pkg::smul16(vec.src_y, vec.dst_x);
    ls_c = $unsigned(p_sxx) + $unsigned(p_syy) + $unsigned(p_szz);
    ld_c = $unsigned(p_dxx) + $unsigned(p_dyy) + $unsigned(p_dzz);
    fr_c.dot  = 34'(p_xx) + 34'(p_yy) + 34'(p_zz);
    fr_c.cx   = 33'(p_ydz) - 33'(p_zdy);
    fr_c.cy   = 33'(p_zdx) - 33'(p_xdz);
    fr_c.cz   = 33'(p_xdy) - 33'(p_ydx);
    fr_c.sx   = vec.src_x;
    fr_c.sy   = vec.src_y;
    fr_c.sz   = vec.src_z;
    fr_c.zero = (vec.src_x == '0 && vec.src_y == '0 && vec.src_z == '0) ||
                (vec.dst_x == '0 && vec.dst_y == '0 && vec.dst_z == '0);
  end

  // stage b: |s|^2 * |d|^2
  logic [63:0] prod_b;

  always_ff @(posedge clk) begin
    ls_a   <= ls_c;
    ld_a   <= ld_c;
    fr_a   <= fr_c;
    prod_b <= 64'(ls_a) * 64'(ld_a);
    fr_b   <= fr_a;
  end

  // m = sqrt(|s|^2 * |d|^2)
  logic [31:0] m_root;
  front_t      fr_dly [qftv_pkg::SQRT_STAGES];

  qftv_isqrt u_sqrt_m (
    .clk  (clk),
    .rad  (prod_b),
    .root (m_root)
  );

  always_ff @(posedge clk) begin
    fr_dly[0] <= fr_b;
    for (int i = 1; i < qftv_pkg::SQRT_STAGES; i++) fr_dly[i] <= fr_dly[i-1];
  end

  // stages c and d: real part and its scaled copy for the opposite test
  logic [32:0] r_c, r_d;
  logic [31:0] m_c, m_d;
  logic [52:0] rm_d;

  always_ff @(posedge clk) begin
    r_c   <= 33'(34'(m_root) + fr_dly[qftv_pkg::SQRT_STAGES-1].dot);
    m_c   <= m_root;
    fr_c2 <= fr_dly[qftv_pkg::SQRT_STAGES-1];
    rm_d  <= 53'(r_c) * 53'(qftv_pkg::OPP_SCALE);
    r_d   <= r_c;
    m_d   <= m_c;
    fr_d  <= fr_c2;
  end

  // stage e: pick the quaternion, split into sign and magnitude
  logic               opp_c;
  logic [16:0]        abs_sx, abs_sz;
  logic signed [33:0] qv [4];
  logic [3:0][32:0]   mag_e_c;
  logic [3:0]         neg_e_c;
  logic [3:0][32:0]   mag_e;
  logic [3:0]         neg_e;
  logic               opp_e, zero_e;

  always_comb begin
    opp_c  = rm_d < 53'(m_d);
    abs_sx = fr_d.sx[15] ? 17'(-18'(fr_d.sx)) : 17'(fr_d.sx);
    abs_sz = fr_d.sz[15] ? 17'(-18'(fr_d.sz)) : 17'(fr_d.sz);
    if (!opp_c) begin
      qv[0] = 34'(r_d);
      qv[1] = 34'(fr_d.cx);
      qv[2] = 34'(fr_d.cy);
      qv[3] = 34'(fr_d.cz);
    end else if (abs_sx > abs_sz) begin
      qv[0] = '0;
      qv[1] = -34'(fr_d.sy);
      qv[2] = 34'(fr_d.sx);
      qv[3] = '0;
    end else begin
      qv[0] = '0;
      qv[1] = '0;
      qv[2] = -34'(fr_d.sz);
      qv[3] = 34'(fr_d.sy);
    end
    for (int i = 0; i < 4; i++) begin
      neg_e_c[i] = qv[i][33];
      mag_e_c[i] = neg_e_c[i] ? 33'(-qv[i]) : 33'(qv[i]);
    end
  end

  // stages f and g: leading one of the largest magnitude, then common shift
  logic [5:0]       pos_f;
  logic [3:0][32:0] mag_f;
  logic [3:0]       neg_f, neg_g;
  logic             opp_f, zero_f, opp_g, zero_g;
  logic [3:0][29:0] mag_g_c, mag_g;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (pos_f >= qftv_pkg::NORM_MSB) begin
        mag_g_c[i] = 30'(mag_f[i] >> (pos_f - qftv_pkg::NORM_MSB));
      end else begin
        mag_g_c[i] = 30'(mag_f[i] << (qftv_pkg::NORM_MSB - pos_f));
      end
    end
  end

  // stages h and i: sum of squares
  logic [3:0][59:0] sq_h;
  back_t            bk_h, bk_i;
  logic [61:0]      n2_i;

  always_ff @(posedge clk) begin
    mag_e  <= mag_e_c;
    neg_e  <= neg_e_c;
    opp_e  <= opp_c;
    zero_e <= fr_d.zero;
    pos_f  <= qftv_pkg::lead_pos(mag_e[0] | mag_e[1] | mag_e[2] | mag_e[3]);
    mag_f  <= mag_e;
    neg_f  <= neg_e;
    opp_f  <= opp_e;
    zero_f <= zero_e;
    mag_g  <= mag_g_c;
    neg_g  <= neg_f;
    opp_g  <= opp_f;
    zero_g <= zero_f;
    for (int i = 0; i < 4; i++) sq_h[i] <= 60'(mag_g[i]) * 60'(mag_g[i]);
    bk_h.mag  <= mag_g;
    bk_h.neg  <= neg_g;
    bk_h.opp  <= opp_g;
    bk_h.zero <= zero_g;
    n2_i <= 62'(sq_h[0]) + 62'(sq_h[1]) + 62'(sq_h[2]) + 62'(sq_h[3]);
    bk_i <= bk_h;
  end

  // norm and per-component division
  logic [31:0] n_root;
  back_t       bk_dly [qftv_pkg::SQRT_STAGES];
  tail_t       tl_dly [qftv_pkg::DIV_STAGES];
  logic [qftv_pkg::QBITS-1:0] quo [4];

  qftv_isqrt u_sqrt_n (
    .clk  (clk),
    .rad  ({2'b00, n2_i}),
    .root (n_root)
  );

  always_ff @(posedge clk) begin
    bk_dly[0] <= bk_i;
    for (int i = 1; i < qftv_pkg::SQRT_STAGES; i++) bk_dly[i] <= bk_dly[i-1];
    tl_dly[0].neg  <= bk_dly[qftv_pkg::SQRT_STAGES-1].neg;
    tl_dly[0].opp  <= bk_dly[qftv_pkg::SQRT_STAGES-1].opp;
    tl_dly[0].zero <= bk_dly[qftv_pkg::SQRT_STAGES-1].zero;
    for (int i = 1; i < qftv_pkg::DIV_STAGES; i++) tl_dly[i] <= tl_dly[i-1];
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    qftv_div u_div (
      .clk (clk),
      .mag (bk_dly[qftv_pkg::SQRT_STAGES-1].mag[g]),
      .nrm (n_root[30:0]),
      .quo (quo[g])
    );
  end

  // sign and zero-input override
  tail_t tl_o;
  logic signed [15:0] comp [4];

  always_comb begin
    tl_o = tl_dly[qftv_pkg::DIV_STAGES-1];
    for (int i = 0; i < 4; i++) begin
      if (tl_o.zero) comp[i] = '0;
      else if (tl_o.neg[i]) comp[i] = -16'(quo[i]);
      else comp[i] = 16'(quo[i]);
    end
    res.quat_w          = comp[0];
    res.quat_x          = comp[1];
    res.quat_y          = comp[2];
    res.quat_z          = comp[3];
    res.opposite_flag   = tl_o.opp && !tl_o.zero;
    res.zero_input_flag = tl_o.zero;
  end

  // control: valid bits and buffer credits
  // a word leaving in the same cycle frees the slot for a new one
  assign vec_ready = !rst &&
                     ((credit != (qftv_pkg::FIFO_AW+1)'(qftv_pkg::FIFO_DEPTH)) || pop);
  assign accept    = vec_valid && vec_ready;
  assign push      = vld[qftv_pkg::LATENCY-1];
  assign pop       = quat_valid && quat_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      credit <= '0;
    end else begin
      vld <= {vld[qftv_pkg::LATENCY-2:0], accept};
      case ({accept, pop})
        2'b10:   credit <= credit + 1'b1;
        2'b01:   credit <= credit - 1'b1;
        default: credit <= credit;
      endcase
    end
  end

  qftv_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (res),
    .pop   (pop),
    .rdata (quat),
    .stat  (fstat)
  );

  assign quat_valid = !fstat.empty;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !fstat.full)
    else $error("result buffer written while full");

  a_credit_cover: assert property (@(posedge clk) disable iff (rst)
    fstat.level <= credit)
    else $error("buffer holds more words than credits taken");

  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    push |-> credit != '0)
    else $error("result emerged with no word in flight");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (quat_valid && quat.zero_input_flag) |->
      (quat.quat_w == '0 && quat.quat_x == '0 && quat.quat_y == '0 &&
       quat.quat_z == '0 && !quat.opposite_flag))
    else $error("zero-input word carries a nonzero quaternion");

endmodule

FILE: tb/testbench.sv
// testbench for the quaternion-from-two-vectors block
`timescale 1ns / 100ps

module testbench;

  logic            clk;
  logic            rst;
  logic            vec_valid;
  logic            vec_ready;
  qftv_pkg::vec_t  vec;
  logic            quat_valid;
  logic            quat_ready;
  qftv_pkg::quat_t quat;

  qftv_pkg::vec_t  pending_vecs[$];
  qftv_pkg::quat_t expected_quats[$];
  int    err_count;
  int    send_idle_pct;
  int    recv_stall_pct;
  bit    hold_send;
  bit    in_taken;

  quat_from_two_vectors DUT (
    .clk(clk), .rst(rst),
    .vec_valid(vec_valid), .vec_ready(vec_ready), .vec(vec),
    .quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] op, res, one;
    op = x;
    res = '0;
    one = 64'd1 << 62;
    while (one > op) one = one >> 2;
    while (one != 0) begin
      if (op >= res + one) begin
        op = op - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  function automatic qftv_pkg::quat_t rotation_quat(input qftv_pkg::vec_t v);
    longint sx, sy, sz, dx, dy, dz, dot;
    longint q[4];
    logic [63:0] ls, ld, m, r, mx, n2, n, qv;
    logic [63:0] mag[4];
    bit neg[4];
    qftv_pkg::quat_t res;
    sx = v.src_x; sy = v.src_y; sz = v.src_z;
    dx = v.dst_x; dy = v.dst_y; dz = v.dst_z;
    res = '0;
    ls = sx * sx + sy * sy + sz * sz;
    ld = dx * dx + dy * dy + dz * dz;
    if (ls == 0 || ld == 0) begin
      res.zero_input_flag = 1'b1;
      return res;
    end
    m = int_sqrt(ls * ld);
    dot = sx * dx + sy * dy + sz * dz;
    r = longint'(m) + dot;
    if (r * 64'd1000000 < m) begin
      // opposite vectors: fixed orthogonal axis
      q[0] = 0;
      if ((sx < 0 ? -sx : sx) > (sz < 0 ? -sz : sz)) begin
        q[1] = -sy; q[2] = sx; q[3] = 0;
      end else begin
        q[1] = 0; q[2] = -sz; q[3] = sy;
      end
      res.opposite_flag = 1'b1;
    end else begin
      q[0] = longint'(r);
      q[1] = sy * dz - sz * dy;
      q[2] = sz * dx - sx * dz;
      q[3] = sx * dy - sy * dx;
    end
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = q[i] < 0;
      mag[i] = neg[i] ? -q[i] : q[i];
      if (mag[i] > mx) mx = mag[i];
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
    end
    n2 = 0;
    for (int i = 0; i < 4; i++) n2 = n2 + mag[i] * mag[i];
    n = int_sqrt(n2);
    for (int i = 0; i < 4; i++) begin
      qv = ((mag[i] << 15) + n) / (n << 1);
      if (neg[i]) qv = -qv;
      case (i)
        0: res.quat_w = qv[15:0];
        1: res.quat_x = qv[15:0];
        2: res.quat_y = qv[15:0];
        default: res.quat_z = qv[15:0];
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      vec_valid <= 1'b0;
      vec <= '0;
      quat_ready <= 1'b0;
    end else begin
      if (!vec_valid || in_taken) begin
        if (pending_vecs.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          vec <= pending_vecs.pop_front();
          vec_valid <= 1'b1;
        end else begin
          vec_valid <= 1'b0;
        end
      end
      quat_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    qftv_pkg::quat_t want;
    in_taken <= !rst && vec_valid && vec_ready;
    if (!rst && vec_valid && vec_ready) begin
      expected_quats.push_back(rotation_quat(vec));
    end
    if (!rst && quat_valid && quat_ready) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_quats.pop_front();
        if (quat.quat_w !== want.quat_w) report_mismatch("quat_w", quat.quat_w, want.quat_w);
        if (quat.quat_x !== want.quat_x) report_mismatch("quat_x", quat.quat_x, want.quat_x);
        if (quat.quat_y !== want.quat_y) report_mismatch("quat_y", quat.quat_y, want.quat_y);
        if (quat.quat_z !== want.quat_z) report_mismatch("quat_z", quat.quat_z, want.quat_z);
        if (quat.opposite_flag !== want.opposite_flag)
          report_mismatch("opposite_flag", quat.opposite_flag, want.opposite_flag);
        if (quat.zero_input_flag !== want.zero_input_flag)
          report_mismatch("zero_input_flag", quat.zero_input_flag, want.zero_input_flag);
      end
    end
  end

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(16)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic qftv_pkg::vec_t make_vec(input int sx, sy, sz, dx, dy, dz);
    qftv_pkg::vec_t v;
    v.src_x = 16'(sx); v.src_y = 16'(sy); v.src_z = 16'(sz);
    v.dst_x = 16'(dx); v.dst_y = 16'(dy); v.dst_z = 16'(dz);
    return v;
  endfunction

  function automatic qftv_pkg::vec_t rand_vec();
    qftv_pkg::vec_t v;
    int k;
    v = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    case ($urandom_range(9))
      0: begin  // opposite pair
        k = $urandom_range(1, 3);
        v.dst_x = -v.src_x / k; v.dst_y = -v.src_y / k; v.dst_z = -v.src_z / k;
      end
      1: begin  // parallel pair
        v.dst_x = v.src_x; v.dst_y = v.src_y; v.dst_z = v.src_z;
      end
      2: begin  // nearly opposite
        v.dst_x = -v.src_x + 16'($urandom_range(2)) - 16'sd1;
        v.dst_y = -v.src_y; v.dst_z = -v.src_z;
      end
      3: if ($urandom_range(3) == 0) begin
        v.src_x = 0; v.src_y = 0; v.src_z = 0;
      end else begin
        v.dst_x = 0; v.dst_y = 0; v.dst_z = 0;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic drain();
    wait (pending_vecs.size() == 0 && expected_quats.size() == 0 && !vec_valid);
  endtask

  initial begin
    rst = 1'b1;
    err_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_send = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed: extremes, zero vectors, opposite and parallel cases
    pending_vecs.push_back(make_vec(0, 0, 0, 4096, 0, 0));
    pending_vecs.push_back(make_vec(4096, 0, 0, 0, 0, 0));
    pending_vecs.push_back(make_vec(0, 0, 0, 0, 0, 0));
    pending_vecs.push_back(make_vec(4096, 0, 0, 0, 4096, 0));
    pending_vecs.push_back(make_vec(4096, 0, 0, 4096, 0, 0));
    pending_vecs.push_back(make_vec(4096, 0, 0, -4096, 0, 0));
    pending_vecs.push_back(make_vec(0, 0, 4096, 0, 0, -4096));
    pending_vecs.push_back(make_vec(100, 5, 100, -100, -5, -100));
    pending_vecs.push_back(make_vec(-3, 7, 2, 3, -7, -2));
    pending_vecs.push_back(make_vec(-32768, -32768, -32768, -32768, -32768, -32768));
    pending_vecs.push_back(make_vec(-32768, -32768, -32768, 32767, 32767, 32767));
    pending_vecs.push_back(make_vec(32767, 32767, 32767, -32768, -32768, -32768));
    pending_vecs.push_back(make_vec(32767, -32768, 0, -32768, 32767, 1));
    pending_vecs.push_back(make_vec(1, 0, 0, 0, 0, 1));
    pending_vecs.push_back(make_vec(1, 0, 0, -1, 1, 0));
    pending_vecs.push_back(make_vec(30000, 1, 0, -30000, 0, 0));
    pending_vecs.push_back(make_vec(-1, -1, -1, 1, 1, 1));
    pending_vecs.push_back(make_vec(0, 32767, 0, 0, -32768, 0));
    drain();

    // random phases; the third holds sending midway until every expected word is back
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        3: begin send_idle_pct = 12; recv_stall_pct = 12; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 260; i++) pending_vecs.push_back(rand_vec());
      if (ph == 2) begin
        wait (pending_vecs.size() < 130);
        hold_send = 1'b1;
        wait (!vec_valid);
        wait (expected_quats.size() == 0);
        hold_send = 1'b0;
      end
      drain();
    end
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
